// ----- rtl/ahcfp_pkg.sv -----
// Package for the ASCII hex frame parser: phase encoding, character codes,
// hex digit decode and the byte-wide CRC-8 update. No dependencies.
package ahcfp_pkg;

  localparam int unsigned MaxDataBytes = 8;
  localparam int unsigned IdWidth      = 29;
  localparam int unsigned LenWidth     = 4;
  localparam int unsigned CntWidth     = 4;
  localparam int unsigned IdxWidth     = 3;

  localparam logic [7:0] CharStartLo = 8'h6D;  // 'm'
  localparam logic [7:0] CharStartUp = 8'h4D;  // 'M'
  localparam logic [7:0] CharComma   = 8'h2C;  // ','
  localparam logic [7:0] CharSemi    = 8'h3B;  // ';'
  localparam logic [7:0] CrcPoly     = 8'h07;

  localparam logic [CntWidth-1:0] IdDigits   = CntWidth'(8);
  localparam logic [CntWidth-1:0] ByteDigits = CntWidth'(2);

  typedef enum logic [4:0] {
    PhWait = 5'b00001,
    PhId   = 5'b00010,
    PhSep  = 5'b00100,
    PhData = 5'b01000,
    PhChk  = 5'b10000
  } phase_e;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] ch);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'h0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      h.val = 4'(ch - 8'h30);
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      h.val = 4'(ch - 8'h37);
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      h.val = 4'(ch - 8'h57);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    r = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (r[7]) begin
        r = {r[6:0], 1'b0} ^ CrcPoly;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/ascii_hex_can_frame_parser_unit.sv -----
// ASCII hex frame parser with CRC-8 check: character register, one-hot parse
// state update and a result register. Depends on ahcfp_pkg.
//
//  channel | valid      | ready       | payload
//  --------+------------+-------------+------------------------------------
//  input   | in_valid_i | in_ready_o  | char_in_i
//  result  | out_valid_o| out_ready_i | msg_id_o, msg_len_o, byte0_o..byte7_o
//
// One item per cycle unless a result waits untaken: a character is registered,
// then parsed into the frame state when the parse stage is not stalled; a
// matching checksum loads the result register.
// Reset returns the parser to waiting for a start character with empty stages.
// A result not taken stalls only the parse stage, and input stalls behind it.
module ascii_hex_can_frame_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [28:0] msg_id_o,
  output logic [3:0]  msg_len_o,
  output logic [7:0]  byte0_o,
  output logic [7:0]  byte1_o,
  output logic [7:0]  byte2_o,
  output logic [7:0]  byte3_o,
  output logic [7:0]  byte4_o,
  output logic [7:0]  byte5_o,
  output logic [7:0]  byte6_o,
  output logic [7:0]  byte7_o
);

  logic                                   chr_vld_q;
  logic [7:0]                             chr_q;
  logic                                   proc_en;

  ahcfp_pkg::phase_e                      phase_q, phase_d;
  logic [ahcfp_pkg::IdWidth-1:0]          id_q, id_d;
  logic [ahcfp_pkg::LenWidth-1:0]         bcnt_q, bcnt_d;
  logic [ahcfp_pkg::CntWidth-1:0]         dcnt_q, dcnt_d;
  logic [7:0]                             crc_q, crc_d;
  logic [7:0]                             exp_q, exp_d;
  logic [7:0]                             store_q [ahcfp_pkg::MaxDataBytes];
  logic                                   store_we;
  logic [ahcfp_pkg::IdxWidth-1:0]         store_idx;
  logic [7:0]                             store_wd;
  logic                                   hit;

  logic                                   out_vld_q;
  logic [ahcfp_pkg::IdWidth-1:0]          out_id_q;
  logic [ahcfp_pkg::LenWidth-1:0]         out_len_q;
  logic [7:0]                             out_byte_q [ahcfp_pkg::MaxDataBytes];

  assign proc_en    = chr_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !chr_vld_q || proc_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chr_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      chr_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      chr_q <= char_in_i;
    end
  end

  always_comb begin
    ahcfp_pkg::hex_t                hx;
    logic [ahcfp_pkg::CntWidth-1:0] dnext;
    logic [7:0]                     cur;
    hx        = ahcfp_pkg::hex_decode(chr_q);
    dnext     = dcnt_q + 1'b1;
    store_idx = ahcfp_pkg::IdxWidth'(bcnt_q - 1'b1);
    cur       = store_q[store_idx];
    phase_d   = phase_q;
    id_d      = id_q;
    bcnt_d    = bcnt_q;
    dcnt_d    = dcnt_q;
    crc_d     = crc_q;
    exp_d     = exp_q;
    store_we  = 1'b0;
    store_wd  = 8'h00;
    hit       = 1'b0;
    unique case (phase_q)
      ahcfp_pkg::PhWait: begin
        if (chr_q == ahcfp_pkg::CharStartLo || chr_q == ahcfp_pkg::CharStartUp) begin
          id_d    = '0;
          bcnt_d  = '0;
          crc_d   = 8'h00;
          dcnt_d  = '0;
          phase_d = ahcfp_pkg::PhId;
        end
      end
      ahcfp_pkg::PhId: begin
        if (!hx.ok) begin
          phase_d = ahcfp_pkg::PhWait;
        end else begin
          id_d   = {id_q[ahcfp_pkg::IdWidth-5:0], hx.val};
          dcnt_d = dnext;
          if (!dnext[0]) begin
            crc_d = ahcfp_pkg::crc8_byte(crc_q, {id_q[3:0], hx.val});
          end
          if (dnext >= ahcfp_pkg::IdDigits) begin
            phase_d = ahcfp_pkg::PhSep;
          end
        end
      end
      ahcfp_pkg::PhSep: begin
        if (chr_q == ahcfp_pkg::CharComma) begin
          dcnt_d = '0;
          if (bcnt_q < ahcfp_pkg::LenWidth'(ahcfp_pkg::MaxDataBytes)) begin
            store_idx = ahcfp_pkg::IdxWidth'(bcnt_q);
            store_we  = 1'b1;
            store_wd  = 8'h00;
            bcnt_d    = bcnt_q + 1'b1;
            phase_d   = ahcfp_pkg::PhData;
          end else begin
            phase_d = ahcfp_pkg::PhWait;
          end
        end else if (chr_q == ahcfp_pkg::CharSemi) begin
          dcnt_d  = '0;
          phase_d = ahcfp_pkg::PhChk;
        end else begin
          phase_d = ahcfp_pkg::PhWait;
        end
      end
      ahcfp_pkg::PhData: begin
        if (!hx.ok) begin
          phase_d = ahcfp_pkg::PhWait;
        end else begin
          store_we = 1'b1;
          store_wd = {cur[3:0], hx.val};
          dcnt_d   = dnext;
          if (dnext >= ahcfp_pkg::ByteDigits) begin
            crc_d   = ahcfp_pkg::crc8_byte(crc_q, {cur[3:0], hx.val});
            phase_d = ahcfp_pkg::PhSep;
          end
        end
      end
      ahcfp_pkg::PhChk: begin
        if (!hx.ok) begin
          phase_d = ahcfp_pkg::PhWait;
        end else begin
          exp_d  = {exp_q[3:0], hx.val};
          dcnt_d = dnext;
          if (dnext == ahcfp_pkg::ByteDigits) begin
            phase_d = ahcfp_pkg::PhWait;
            hit     = ({exp_q[3:0], hx.val} == crc_q);
          end
        end
      end
      default: begin
        phase_d = ahcfp_pkg::PhWait;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ahcfp_pkg::PhWait;
      id_q    <= '0;
      bcnt_q  <= '0;
      dcnt_q  <= '0;
      crc_q   <= 8'h00;
      exp_q   <= 8'h00;
      for (int i = 0; i < ahcfp_pkg::MaxDataBytes; i++) begin
        store_q[i] <= 8'h00;
      end
    end else if (proc_en) begin
      phase_q <= phase_d;
      id_q    <= id_d;
      bcnt_q  <= bcnt_d;
      dcnt_q  <= dcnt_d;
      crc_q   <= crc_d;
      exp_q   <= exp_d;
      if (store_we) begin
        store_q[store_idx] <= store_wd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (proc_en) begin
      out_vld_q <= hit;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_en && hit) begin
      out_id_q  <= id_q;
      out_len_q <= bcnt_q;
      for (int k = 0; k < ahcfp_pkg::MaxDataBytes; k++) begin
        out_byte_q[k] <= (ahcfp_pkg::LenWidth'(k) < bcnt_q) ? store_q[k] : 8'h00;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign msg_id_o    = out_id_q;
  assign msg_len_o   = out_len_q;
  assign byte0_o     = out_byte_q[0];
  assign byte1_o     = out_byte_q[1];
  assign byte2_o     = out_byte_q[2];
  assign byte3_o     = out_byte_q[3];
  assign byte4_o     = out_byte_q[4];
  assign byte5_o     = out_byte_q[5];
  assign byte6_o     = out_byte_q[6];
  assign byte7_o     = out_byte_q[7];

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for ascii_hex_can_frame_parser_unit: directed and random
// character streams, a frame decoder model and an in-order check of every frame.
// Depends on ahcfp_pkg and the parser unit.
module tb_top;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned LongHold  = 200;
  localparam int unsigned RandChars = 1500;
  localparam int unsigned Phases    = 10;

  typedef struct packed {
    logic [ahcfp_pkg::IdWidth-1:0]  id;
    logic [ahcfp_pkg::LenWidth-1:0] len;
    logic [7:0][7:0]                data;
  } frame_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              out_ready = 1'b0;
  logic [7:0]        char_in   = 8'h00;
  logic              in_ready;
  logic              out_valid;
  logic [ahcfp_pkg::IdWidth-1:0]  msg_id;
  logic [ahcfp_pkg::LenWidth-1:0] msg_len;
  logic [7:0]        rx_byte [8];

  // frame decoder state
  ahcfp_pkg::phase_e ph;
  logic [ahcfp_pkg::IdWidth-1:0] id_acc;
  logic [3:0]        nbytes;
  logic [3:0]        ndig;
  logic [7:0][7:0]   store;
  logic [7:0]        crc_run;
  logic [7:0]        crc_rx;
  frame_t            frames_due[$];

  logic [7:0]        char_q[$];
  logic [7:0]        frame_buf[$];
  int unsigned       chars_queued   = 0;
  int unsigned       chars_accepted = 0;
  int unsigned       counted        = 0;
  int unsigned       idle_cycles    = 0;
  int unsigned       errors         = 0;
  int unsigned       tx_gap_max     = 0;
  int unsigned       rx_gap_max     = 0;
  int unsigned       tx_wait        = 0;
  int unsigned       rx_wait        = 0;
  int unsigned       long_hold_reqs = 0;
  int unsigned       long_hold_done = 0;
  bit                in_taken       = 1'b0;
  bit                out_taken      = 1'b0;

  ascii_hex_can_frame_parser_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .char_in_i   (char_in),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .msg_id_o    (msg_id),
    .msg_len_o   (msg_len),
    .byte0_o     (rx_byte[0]),
    .byte1_o     (rx_byte[1]),
    .byte2_o     (rx_byte[2]),
    .byte3_o     (rx_byte[3]),
    .byte4_o     (rx_byte[4]),
    .byte5_o     (rx_byte[5]),
    .byte6_o     (rx_byte[6]),
    .byte7_o     (rx_byte[7])
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 10)};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 10)};
    return 5'b0_0000;
  endfunction

  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    r = crc ^ b;
    for (int i = 0; i < 8; i++) r = r[7] ? ((r << 1) ^ ahcfp_pkg::CrcPoly) : (r << 1);
    return r;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 10) return 8'("0" + v);
    return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
  endfunction

  task automatic parse_char(input logic [7:0] c);
    logic [4:0] h;
    logic [2:0] idx;
    frame_t     f;
    h = hex_nibble(c);
    case (ph)
      ahcfp_pkg::PhWait: begin
        if (c == ahcfp_pkg::CharStartLo || c == ahcfp_pkg::CharStartUp) begin
          id_acc  = '0;
          nbytes  = '0;
          crc_run = '0;
          ndig    = '0;
          ph      = ahcfp_pkg::PhId;
        end
      end
      ahcfp_pkg::PhId: begin
        if (!h[4]) ph = ahcfp_pkg::PhWait;
        else begin
          id_acc = {id_acc[ahcfp_pkg::IdWidth-5:0], h[3:0]};
          ndig++;
          if (!ndig[0]) crc_run = crc_step(crc_run, id_acc[7:0]);
          if (ndig >= 8) ph = ahcfp_pkg::PhSep;
        end
      end
      ahcfp_pkg::PhSep: begin
        if (c == ahcfp_pkg::CharComma) begin
          ndig = '0;
          if (nbytes < ahcfp_pkg::MaxDataBytes) begin
            store[nbytes[2:0]] = '0;
            nbytes++;
            ph = ahcfp_pkg::PhData;
          end else ph = ahcfp_pkg::PhWait;
        end else if (c == ahcfp_pkg::CharSemi) begin
          ndig = '0;
          ph   = ahcfp_pkg::PhChk;
        end else ph = ahcfp_pkg::PhWait;
      end
      ahcfp_pkg::PhData: begin
        if (!h[4]) ph = ahcfp_pkg::PhWait;
        else begin
          idx        = 3'(nbytes - 1);
          store[idx] = {store[idx][3:0], h[3:0]};
          ndig++;
          if (ndig >= 2) begin
            crc_run = crc_step(crc_run, store[idx]);
            ph      = ahcfp_pkg::PhSep;
          end
        end
      end
      ahcfp_pkg::PhChk: begin
        if (!h[4]) ph = ahcfp_pkg::PhWait;
        else begin
          crc_rx = {crc_rx[3:0], h[3:0]};
          ndig++;
          if (ndig == 2) begin
            ph = ahcfp_pkg::PhWait;
            if (crc_rx == crc_run) begin
              f.id  = id_acc;
              f.len = nbytes;
              for (int k = 0; k < 8; k++) f.data[k] = (k < nbytes) ? store[k] : 8'h00;
              frames_due.push_back(f);
            end
          end
        end
      end
      default: ph = ahcfp_pkg::PhWait;
    endcase
  endtask

  task automatic make_frame(input logic [31:0] id, input int n, input logic [7:0][7:0] d,
                            input logic [7:0] crc_flip);
    logic [7:0] crc;
    logic [7:0] b;
    frame_buf.delete();
    frame_buf.push_back($urandom_range(0, 1) ? ahcfp_pkg::CharStartLo
                                             : ahcfp_pkg::CharStartUp);
    crc = '0;
    for (int i = 7; i >= 0; i--) frame_buf.push_back(hex_char(id[4*i +: 4]));
    for (int i = 3; i >= 0; i--) crc = crc_step(crc, id[8*i +: 8]);
    for (int i = 0; i < n; i++) begin
      b = d[i % 8];
      frame_buf.push_back(ahcfp_pkg::CharComma);
      frame_buf.push_back(hex_char(b[7:4]));
      frame_buf.push_back(hex_char(b[3:0]));
      crc = crc_step(crc, b);
    end
    crc ^= crc_flip;
    frame_buf.push_back(ahcfp_pkg::CharSemi);
    frame_buf.push_back(hex_char(crc[7:4]));
    frame_buf.push_back(hex_char(crc[3:0]));
  endtask

  task automatic send_buf(input bit counts);
    foreach (frame_buf[i]) char_q.push_back(frame_buf[i]);
    chars_queued += frame_buf.size();
    if (counts) counted += frame_buf.size();
  endtask

  task automatic send_noise(input int n);
    frame_buf.delete();
    repeat (n) frame_buf.push_back(8'($urandom_range(0, 255)));
    send_buf(1'b0);
  endtask

  task automatic random_frame();
    int unsigned     kind;
    logic [7:0][7:0] d;
    kind = $urandom_range(0, 99);
    d    = {$urandom, $urandom};
    if (kind >= 92) send_noise($urandom_range(1, 6));
    else begin
      make_frame($urandom, (kind >= 88) ? 9 : $urandom_range(0, 8), d,
                 (kind >= 70 && kind < 80) ? 8'($urandom_range(1, 255)) : 8'h00);
      if (kind >= 80 && kind < 88)
        frame_buf[$urandom_range(1, frame_buf.size() - 1)] = 8'($urandom_range(0, 255));
      send_buf(1'b1);
    end
  endtask

  task automatic drain();
    while (chars_accepted != chars_queued || frames_due.size() != 0) @(negedge clk);
  endtask

  // sender: hold each item until taken, then wait its drawn gap
  always @(negedge clk) begin
    if (!rst_n) in_valid <= 1'b0;
    else if (!in_valid || in_taken) begin
      if (tx_wait > 0) begin
        in_valid <= 1'b0;
        tx_wait--;
      end else if (char_q.size() != 0) begin
        in_valid <= 1'b1;
        char_in  <= char_q.pop_front();
        tx_wait  = $urandom_range(0, tx_gap_max);
      end else in_valid <= 1'b0;
    end
  end

  // receiver: drawn stall per frame, plus the long hold on request
  always @(negedge clk) begin
    if (long_hold_reqs != long_hold_done) begin
      long_hold_done = long_hold_reqs;
      rx_wait        = LongHold;
    end else if (out_taken) rx_wait = $urandom_range(0, rx_gap_max);
    if (!rst_n) out_ready <= 1'b0;
    else if (rx_wait > 0) begin
      out_ready <= 1'b0;
      rx_wait--;
    end else out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    frame_t           got;
    frame_t           want;
    logic   [7:0]     bad_bytes;
    if (rst_n) begin
      in_taken  = in_valid && in_ready;
      out_taken = out_valid && out_ready;
      if (in_taken) begin
        parse_char(char_in);
        chars_accepted++;
      end
      if (out_taken) begin
        got.id  = msg_id;
        got.len = msg_len;
        for (int k = 0; k < 8; k++) got.data[k] = rx_byte[k];
        if (frames_due.size() == 0) begin
          $display("%0t: frame expected none actual id %h len %0d data %h",
                   $time, got.id, got.len, got.data);
          errors++;
        end else begin
          want = frames_due.pop_front();
          for (int k = 0; k < 8; k++) bad_bytes[k] = (got.data[k] !== want.data[k]);
          if (got.id !== want.id) begin
            $display("%0t: msg_id expected %h actual %h", $time, want.id, got.id);
            errors++;
          end
          if (got.len !== want.len) begin
            $display("%0t: msg_len expected %0d actual %0d", $time, want.len, got.len);
            errors++;
          end
          if (bad_bytes != '0) begin
            $display("%0t: data bytes (mask %b) expected %h actual %h",
                     $time, bad_bytes, want.data, got.data);
            errors++;
          end
        end
      end
      idle_cycles = (in_taken || out_taken) ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IdleLimit) @(negedge clk);
    $display("tb_top failed");
    $finish;
  end

  initial begin
    int unsigned target;
    ph      = ahcfp_pkg::PhWait;
    id_acc  = '0;
    nbytes  = '0;
    ndig    = '0;
    store   = '0;
    crc_run = '0;
    crc_rx  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    frame_buf = '{8'h00, 8'hFF, ahcfp_pkg::CharComma, ahcfp_pkg::CharSemi, "5"};
    send_buf(1'b0);
    make_frame(32'hFFFF_FFFF, 0, '0, 8'h00);
    send_buf(1'b1);
    make_frame(32'h0000_0000, 8, 64'hFF00_A55A_0180_7FFF, 8'h00);
    send_buf(1'b1);
    make_frame(32'hABCD_EF01, 1, 64'h0000_0000_0000_005A, 8'h00);
    send_buf(1'b1);
    make_frame(32'h1234_5678, 2, 64'h0000_0000_0000_C3E1, 8'h01);
    send_buf(1'b1);
    make_frame(32'h2468_ACE0, 9, 64'h0102_0304_0506_0708, 8'h00);
    send_buf(1'b1);
    frame_buf = '{ahcfp_pkg::CharStartUp, "1", ahcfp_pkg::CharStartLo,
                  ahcfp_pkg::CharStartUp, "0", "g"};
    send_buf(1'b1);
    make_frame(32'h0F0F_0F0F, 2, 64'h0000_0000_0000_1234, 8'h00);
    frame_buf[9] = ":";
    send_buf(1'b1);
    make_frame(32'h0F0F_0F0F, 2, 64'h0000_0000_0000_1234, 8'h00);
    frame_buf[11] = "z";
    send_buf(1'b1);
    make_frame(32'h1357_9BDF, 1, 64'h0000_0000_0000_0099, 8'h00);
    frame_buf[frame_buf.size() - 1] = "G";
    send_buf(1'b1);
    drain();

    for (int p = 0; p < Phases; p++) begin
      case ($urandom_range(0, 2))
        0: tx_gap_max = 0;
        1: tx_gap_max = 3;
        default: tx_gap_max = 18;
      endcase
      case ($urandom_range(0, 2))
        0: rx_gap_max = 0;
        1: rx_gap_max = 3;
        default: rx_gap_max = 18;
      endcase
      if (p == 0) begin
        tx_gap_max = 0;
        rx_gap_max = 0;
      end
      if (p == Phases / 2) begin
        tx_gap_max = 0;
        long_hold_reqs++;
      end
      target = counted + RandChars / Phases;
      while (counted < target) random_frame();
      drain();
    end

    repeat (10) @(posedge clk);
    if (errors == 0 && frames_due.size() == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule
